[rtl/cubic_bezier_point_sampler_macros.svh]
// assertion macros for the bezier sampler checker
`ifndef CUBIC_BEZIER_POINT_SAMPLER_MACROS_SVH
`define CUBIC_BEZIER_POINT_SAMPLER_MACROS_SVH

// clocked assertion, disabled while reset is held
`define CBPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define CBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cbps_pkg.sv]
package cbps_pkg;

    localparam int CB         = 16;          // coordinate bits
    localparam int MAX_STEPS  = 63;
    localparam int SW         = 6;           // step count width
    localparam logic [SW-1:0] STEP_RESET = 6'd16;
    localparam int CW         = CB + 5;      // coefficient width
    localparam int TW         = 3 * SW;      // k^3 style term width
    localparam int PW         = CW + TW + 1; // product width
    localparam int NW         = PW + 2;      // numerator width
    localparam int DW         = NW + 1;      // dividend width
    localparam int DENW       = TW + 1;      // twice n^3
    localparam int QB         = CB;          // quotient bits

    typedef struct packed {
        logic signed [CB-1:0] start_x;
        logic signed [CB-1:0] start_y;
        logic signed [CB-1:0] start_handle_dx;
        logic signed [CB-1:0] start_handle_dy;
        logic signed [CB-1:0] end_x;
        logic signed [CB-1:0] end_y;
        logic signed [CB-1:0] end_handle_dx;
        logic signed [CB-1:0] end_handle_dy;
    } t_seg;

    typedef struct packed {
        logic signed [CB-1:0] point_x;
        logic signed [CB-1:0] point_y;
        logic                 last_point;
    } t_pt;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QB-1:0] q;
        logic          neg;
        logic          ovf;
    } t_dax;

endpackage

[rtl/cubic_bezier_point_sampler.sv]
// cubic bezier point sampler: one segment in, n+1 points out, one point a cycle while the output is not stalled
// pipeline: 5 arithmetic stages, 16 divider stages and one output stage lie between a
//   point's issue and its output register; the point sequencer issues one k per cycle
//   while the output is not stalled and takes the next segment as the last k issues
// reset: synchronous active low; clears valids, sequencer and sets the step count to 16
module cubic_bezier_point_sampler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cbps_pkg::t_seg       i_seg,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cbps_pkg::t_pt        o_pt,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_data
);
    import cbps_pkg::*;

    // whole pipeline advances unless the output item is held
    logic adv;
    logic in_acc;

    // configuration
    logic [SW-1:0] r_steps;
    logic [SW-1:0] n_clamped;

    // sequencer holding the current segment
    logic                 r_busy;
    logic [SW-1:0]        r_k;
    logic [SW-1:0]        r_n;
    logic signed [CW-1:0] r_cx [4];
    logic signed [CW-1:0] r_cy [4];
    logic signed [CW-1:0] n_cx [4];
    logic signed [CW-1:0] n_cy [4];
    logic                 seq_last;

    // stage 1: squares
    logic                 r1_v, r1_last;
    logic [SW-1:0]        r1_k, r1_n;
    logic [2*SW-1:0]      r1_k2, r1_kn, r1_n2;
    logic signed [CW-1:0] r1_cx [4];
    logic signed [CW-1:0] r1_cy [4];

    // stage 2: cubes
    logic                 r2_v, r2_last;
    logic [TW-1:0]        r2_t [4];
    logic signed [CW-1:0] r2_cx [4];
    logic signed [CW-1:0] r2_cy [4];

    // stage 3: products
    logic                 r3_v, r3_last;
    logic [TW-1:0]        r3_den;
    logic signed [PW-1:0] r3_px [4];
    logic signed [PW-1:0] r3_py [4];

    // stage 4: numerators
    logic                 r4_v, r4_last;
    logic [TW-1:0]        r4_den;
    logic signed [NW-1:0] r4_nx, r4_ny;

    // stage 5: rounding dividends
    logic                 r5_v, r5_last;
    logic [DENW-1:0]      r5_den2;
    t_dax                 r5_x, r5_y;

    // divider stages, one quotient bit each
    logic                 r_dv    [QB];
    logic                 r_dlast [QB];
    logic [DENW-1:0]      r_dden  [QB];
    t_dax                 r_dx    [QB];
    t_dax                 r_dy    [QB];

    // output register
    logic                 r_ov;
    t_pt                  r_out;

    assign adv      = !(r_ov && i_stall);
    assign seq_last = (r_k == r_n);
    assign o_stall  = r_busy && !(adv && seq_last);
    assign in_acc   = i_valid && !o_stall;
    assign o_valid  = r_ov;
    assign o_pt     = r_out;

    // zero means one step, above the limit saturates
    always_comb begin
        priority if (r_steps == '0) begin
            n_clamped = SW'(1);
        end else if (r_steps > SW'(MAX_STEPS)) begin
            n_clamped = SW'(MAX_STEPS);
        end else begin
            n_clamped = r_steps;
        end
    end

    // power basis coefficients a, b, c, d
    function automatic void make_coefs(input logic signed [CB-1:0] p0,
                                       input logic signed [CB-1:0] h0,
                                       input logic signed [CB-1:0] p3,
                                       input logic signed [CB-1:0] h3,
                                       output logic signed [CW-1:0] c [4]);
        logic signed [CW-1:0] e0, e1, e2, e3;
        e0 = CW'(p0);
        e3 = CW'(p3);
        e1 = e0 + CW'(h0);
        e2 = e3 + CW'(h3);
        c[0] = CW'(e3 - 3 * e2 + 3 * e1 - e0);
        c[1] = CW'(3 * e2 - 6 * e1 + 3 * e0);
        c[2] = CW'(3 * e1 - 3 * e0);
        c[3] = e0;
    endfunction

    always_comb begin
        make_coefs(i_seg.start_x, i_seg.start_handle_dx, i_seg.end_x, i_seg.end_handle_dx, n_cx);
        make_coefs(i_seg.start_y, i_seg.start_handle_dy, i_seg.end_y, i_seg.end_handle_dy, n_cy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEP_RESET;
        end else if (i_cfg_we) begin
            r_steps <= i_cfg_data;
        end
    end

    // sequencer: issue k = 0..n, take the next segment as the last k leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (adv && r_busy) begin
            if (seq_last) begin
                r_busy <= 1'b0;
            end
            r_k <= r_k + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_n  <= n_clamped;
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

    // valid bits of the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (adv) begin
            r1_v <= r_busy;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    // payload of the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // squares of k and n
            r1_last <= seq_last;
            r1_k    <= r_k;
            r1_n    <= r_n;
            r1_k2   <= (2*SW)'(r_k) * (2*SW)'(r_k);
            r1_kn   <= (2*SW)'(r_k) * (2*SW)'(r_n);
            r1_n2   <= (2*SW)'(r_n) * (2*SW)'(r_n);
            r1_cx   <= r_cx;
            r1_cy   <= r_cy;

            // k^3, k^2 n, k n^2, n^3
            r2_last <= r1_last;
            r2_t[0] <= TW'(r1_k2) * TW'(r1_k);
            r2_t[1] <= TW'(r1_k2) * TW'(r1_n);
            r2_t[2] <= TW'(r1_kn) * TW'(r1_n);
            r2_t[3] <= TW'(r1_n2) * TW'(r1_n);
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;

            // one multiplier per term and axis
            r3_last <= r2_last;
            r3_den  <= r2_t[3];
            for (int i = 0; i < 4; i++) begin
                r3_px[i] <= r2_cx[i] * $signed({1'b0, r2_t[i]});
                r3_py[i] <= r2_cy[i] * $signed({1'b0, r2_t[i]});
            end

            r4_last <= r3_last;
            r4_den  <= r3_den;
            r4_nx   <= NW'(r3_px[0]) + NW'(r3_px[1]) + NW'(r3_px[2]) + NW'(r3_px[3]);
            r4_ny   <= NW'(r3_py[0]) + NW'(r3_py[1]) + NW'(r3_py[2]) + NW'(r3_py[3]);

            // half away from zero: (2|num| + den) / (2 den)
            r5_last   <= r4_last;
            r5_den2   <= {r4_den, 1'b0};
            r5_x.neg  <= r4_nx[NW-1];
            r5_y.neg  <= r4_ny[NW-1];
            r5_x.rem  <= {(r4_nx[NW-1] ? NW'(-r4_nx) : NW'(r4_nx)), 1'b0} + DW'(r4_den);
            r5_y.rem  <= {(r4_ny[NW-1] ? NW'(-r4_ny) : NW'(r4_ny)), 1'b0} + DW'(r4_den);
            r5_x.q    <= '0;
            r5_y.q    <= '0;
            r5_x.ovf  <= 1'b0;
            r5_y.ovf  <= 1'b0;
        end
    end

    // restoring divider, msb first; the first stage also flags a quotient beyond range
    function automatic t_dax div_step(input t_dax d, input logic [DW-1:0] sub,
                                      input logic [DW-1:0] top, input logic chk);
        t_dax o;
        o = d;
        if (chk && (d.rem >= top)) begin
            o.ovf = 1'b1;
        end
        o.q = {d.q[QB-2:0], 1'b0};
        if (d.rem >= sub) begin
            o.rem  = d.rem - sub;
            o.q[0] = 1'b1;
        end
        return o;
    endfunction

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic            in_v, in_last;
        logic [DENW-1:0] in_den;
        t_dax            in_x, in_y;
        logic [DW-1:0]   sub, top;

        if (j == 0) begin : g_first
            assign in_v    = r5_v;
            assign in_last = r5_last;
            assign in_den  = r5_den2;
            assign in_x    = r5_x;
            assign in_y    = r5_y;
        end else begin : g_next
            assign in_v    = r_dv[j-1];
            assign in_last = r_dlast[j-1];
            assign in_den  = r_dden[j-1];
            assign in_x    = r_dx[j-1];
            assign in_y    = r_dy[j-1];
        end

        assign sub = DW'(in_den) << B;
        assign top = DW'(in_den) << QB;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else if (adv) begin
                r_dv[j] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dlast[j] <= in_last;
                r_dden[j]  <= in_den;
                r_dx[j]    <= div_step(in_x, sub, top, j == 0);
                r_dy[j]    <= div_step(in_y, sub, top, j == 0);
            end
        end
    end

    // sign and saturation
    function automatic logic signed [CB-1:0] finish(input t_dax d);
        logic signed [CB-1:0] r;
        logic [QB-1:0]        mn;
        mn = QB'(1) << (CB - 1);
        priority if (d.ovf) begin
            r = d.neg ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        end else if (d.neg) begin
            r = (d.q > mn) ? {1'b1, {(CB-1){1'b0}}} : CB'(-d.q);
        end else begin
            r = (d.q > mn - QB'(1)) ? {1'b0, {(CB-1){1'b1}}} : CB'(d.q);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_dv[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.point_x    <= finish(r_dx[QB-1]);
            r_out.point_y    <= finish(r_dy[QB-1]);
            r_out.last_point <= r_dlast[QB-1];
        end
    end

endmodule

[rtl/cbps_checker.sv]
`include "cubic_bezier_point_sampler_macros.svh"

module cbps_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input cbps_pkg::t_seg       i_seg,
    input logic                 o_valid,
    input logic                 i_stall,
    input cbps_pkg::t_pt        o_pt,
    input logic                 i_cfg_we,
    input logic [5:0]           i_cfg_data
);
    import cbps_pkg::*;

    // a held output item keeps its value
    `CBPS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_pt), "output item changed while stalled")

    // reset leaves both channels quiet
    `CBPS_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid && !o_stall, "channels active after reset")

    // a taken segment keeps the input stalled while its points issue
    `CBPS_ASSERT(a_seg_busy, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "input not stalled after a segment was taken")

endmodule

bind cubic_bezier_point_sampler cbps_checker u_cbps_checker (.*);
